// ===== rtl/core/ccht_pkg.sv =====
// Package for the cluster chain table: request and result structs,
// request and status codes, entry codes and controller states.
// No dependencies.
`timescale 1ns / 1ps

package ccht_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [27:0] cluster;
    logic [27:0] new_value;
  } req_t;

  typedef struct packed {
    logic [27:0] entry_value;
    logic [10:0] granted;
    logic [1:0]  status;
  } rsp_t;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;
  localparam logic [1:0] REQ_FREE  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  localparam logic [27:0] ENTRY_FREE   = 28'h0000000;
  localparam logic [27:0] ENTRY_BAD    = 28'hFFFFFF7;
  localparam logic [27:0] ENTRY_EOC_LO = 28'hFFFFFF8;
  localparam logic [27:0] ENTRY_EOC    = 28'hFFFFFFF;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic [10:0] COUNT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ALLOC,
    ST_FREE
  } state_t;

endpackage

// ===== rtl/core/ccht_mem.sv =====
// Link table storage: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new value.
`timescale 1ns / 1ps

module ccht_mem #(
  parameter int DEPTH = 1026,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [27:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [27:0]   rdata
);

  logic [27:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      // forward a same-cycle write to the same entry
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== rtl/core/ccht_ctrl.sv =====
// Request sequencer for the cluster chain table: clearing pass, entry
// read/write, allocate scan and free-chain walk. Uses ccht_pkg.
`timescale 1ns / 1ps

module ccht_ctrl #(
  parameter int DEPTH = 1026,
  parameter int AW    = 11,
  parameter int NW    = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ccht_pkg::req_t req,
  output logic           done,
  output ccht_pkg::rsp_t result,
  input  logic           enabled,
  input  logic [NW-1:0]  active,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [27:0]    mem_wdata,
  output logic           mem_re,
  output logic [AW-1:0]  mem_raddr,
  input  logic [27:0]    mem_rdata
);

  ccht_pkg::state_t state, state_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [NW-1:0]    steps, steps_next;
  logic             done_next;
  ccht_pkg::rsp_t   result_next;

  logic [28:0]   limit;
  logic          req_ok;
  logic          link_ok;
  logic [NW-1:0] steps_inc;
  logic [28:0]   ptr_inc;

  assign limit     = 29'(active) + 29'd2;
  assign req_ok    = enabled && (req.cluster >= 28'd2) && ({1'b0, req.cluster} < limit);
  assign link_ok   = (mem_rdata >= 28'd2) && ({1'b0, mem_rdata} < limit);
  assign steps_inc = steps + NW'(1);
  assign ptr_inc   = 29'(ptr) + 29'd1;
  assign busy      = (state != ccht_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccht_pkg::ST_CLEAR;
      ptr   <= '0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      steps <= steps_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    ptr_next    = ptr;
    steps_next  = steps;
    done_next   = 1'b0;
    result_next = '0;
    mem_we      = 1'b0;
    mem_waddr   = ptr;
    mem_wdata   = ccht_pkg::ENTRY_FREE;
    mem_re      = 1'b0;
    mem_raddr   = ptr;
    case (state)
      ccht_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr == AW'(DEPTH - 1)) begin
          state_next = ccht_pkg::ST_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      ccht_pkg::ST_IDLE: begin
        if (start) begin
          case (req.req_type)
            ccht_pkg::REQ_READ: begin
              if (req_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = req.cluster[AW-1:0];
                state_next = ccht_pkg::ST_READ;
              end else begin
                done_next               = 1'b1;
                result_next.entry_value = ccht_pkg::ENTRY_BAD;
                result_next.status      = ccht_pkg::STATUS_INVALID;
              end
            end
            ccht_pkg::REQ_WRITE: begin
              done_next = 1'b1;
              if (req_ok) begin
                mem_we    = 1'b1;
                mem_waddr = req.cluster[AW-1:0];
                mem_wdata = req.new_value;
              end else begin
                result_next.status = ccht_pkg::STATUS_INVALID;
              end
            end
            ccht_pkg::REQ_ALLOC: begin
              if (!enabled) begin
                done_next          = 1'b1;
                result_next.status = ccht_pkg::STATUS_INVALID;
              end else if (active == '0) begin
                done_next          = 1'b1;
                result_next.status = ccht_pkg::STATUS_FULL;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(2);
                ptr_next   = AW'(2);
                state_next = ccht_pkg::ST_ALLOC;
              end
            end
            default: begin
              if (req_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = req.cluster[AW-1:0];
                ptr_next   = req.cluster[AW-1:0];
                steps_next = '0;
                state_next = ccht_pkg::ST_FREE;
              end else begin
                done_next          = 1'b1;
                result_next.status = ccht_pkg::STATUS_INVALID;
              end
            end
          endcase
        end
      end
      ccht_pkg::ST_READ: begin
        done_next               = 1'b1;
        result_next.entry_value = mem_rdata;
        state_next              = ccht_pkg::ST_IDLE;
      end
      ccht_pkg::ST_ALLOC: begin
        // entry at ptr is on the read data; if it is taken and ptr+1 is in range, the read of ptr+1 goes out meanwhile
        if (mem_rdata == ccht_pkg::ENTRY_FREE) begin
          mem_we              = 1'b1;
          mem_wdata           = ccht_pkg::ENTRY_EOC;
          done_next           = 1'b1;
          result_next.granted = 11'(ptr);
          state_next          = ccht_pkg::ST_IDLE;
        end else if (ptr_inc >= limit) begin
          done_next          = 1'b1;
          result_next.status = ccht_pkg::STATUS_FULL;
          state_next         = ccht_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
          ptr_next  = ptr_inc[AW-1:0];
        end
      end
      ccht_pkg::ST_FREE: begin
        // clear the visited entry and follow its old link
        mem_we = 1'b1;
        if ((mem_rdata >= ccht_pkg::ENTRY_EOC_LO) || !link_ok || (steps_inc >= active)) begin
          done_next  = 1'b1;
          state_next = ccht_pkg::ST_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = mem_rdata[AW-1:0];
          ptr_next   = mem_rdata[AW-1:0];
          steps_next = steps_inc;
        end
      end
      default: begin
        state_next = ccht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cluster_chain_table.sv =====
// Top level of the cluster chain table: configuration registers, the
// active cluster count, the sequencer and the link memory. Uses ccht_pkg.
`timescale 1ns / 1ps

// After reset the block clears its MAX_CLUSTERS+2 entry link memory (1026
// entries by default), one entry a cycle, and holds busy high until the
// clearing pass is over; configuration writes are taken during that time.
// A request is taken when start is high and busy is low, and its result
// shows on result for exactly one cycle with done high; there is no way to
// hold it off. A write reports done in the cycle after it is taken; a read
// goes through the memory's registered read port, then the read state and
// the registered done and result. Allocate scans one entry per cycle from
// cluster 2; free-chain visits one link per cycle and frees at most
// clusters_in_use entries. Rejected requests report done in the cycle after
// they are taken. A new request may be issued in the cycle in which done shows.
module cluster_chain_table #(
  parameter int MAX_CLUSTERS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ccht_pkg::req_t req,
  output logic           done,
  output ccht_pkg::rsp_t result,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [10:0]    cfg_data
);

  localparam int DEPTH = MAX_CLUSTERS + 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_CLUSTERS + 1);

  logic          table_enabled;
  logic [10:0]   clusters_in_use;
  logic [NW-1:0] active;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [27:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [27:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_enabled   <= 1'b0;
      clusters_in_use <= ccht_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ccht_pkg::CFG_ENABLE: table_enabled   <= cfg_data[0];
        ccht_pkg::CFG_COUNT:  clusters_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the programmed count at the table size
  always_comb begin
    if (32'(clusters_in_use) > 32'(MAX_CLUSTERS)) begin
      active = NW'(MAX_CLUSTERS);
    end else begin
      active = NW'(clusters_in_use);
    end
  end

  ccht_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .NW    (NW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .enabled   (table_enabled),
    .active    (active),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ccht_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/core/ccht_checker.sv =====
// Port-level checks for the cluster chain table, bound to the top level.
// Uses ccht_pkg.
`timescale 1ns / 1ps

module ccht_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input ccht_pkg::rsp_t result
);

  // a transfer either finishes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither finished nor busy");

  // reset starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> busy)
    else $error("not busy after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> ((result.status == ccht_pkg::STATUS_OK)
           || (result.status == ccht_pkg::STATUS_INVALID)
           || (result.status == ccht_pkg::STATUS_FULL)))
    else $error("undefined status code");

  // a full table grants nothing and reads nothing
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ccht_pkg::STATUS_FULL))
      |-> ((result.granted == 11'd0) && (result.entry_value == 28'd0)))
    else $error("full status with payload");

  // a granted cluster never carries an entry value
  a_grant_alone: assert property (@(posedge clk) disable iff (rst)
    (done && (result.granted != 11'd0))
      |-> ((result.status == ccht_pkg::STATUS_OK) && (result.entry_value == 28'd0)))
    else $error("grant mixed with other result");

endmodule

bind cluster_chain_table ccht_checker u_ccht_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== dv/tb_cluster_chain_table.sv =====
// Self-checking testbench for cluster_chain_table: directed and random requests
// against a shadow copy of the link table, checked one response per transfer.
// Depends on ccht_pkg and the cluster_chain_table RTL.
`timescale 1ns / 1ps

module tb_cluster_chain_table;
  import ccht_pkg::*;

  localparam int          MAX_CLUSTERS  = 1024;
  localparam int          TABLE_DEPTH   = MAX_CLUSTERS + 2;
  localparam int          TW            = $clog2(TABLE_DEPTH);
  localparam int          RANDOM_ITEMS  = 1500;
  localparam int unsigned CYCLE_LIMIT   = 7_000_000;

  // Shadow of the link table plus the queue of responses still owed by the block.
  class link_table_board;
    logic [27:0] shadow_links [0:TABLE_DEPTH-1];
    logic        enabled;
    logic [10:0] count_reg;
    rsp_t        expected_responses [$];
    int          mismatches;
    int          checked;

    function new();
      foreach (shadow_links[i]) shadow_links[i] = ENTRY_FREE;
      enabled    = 1'b0;
      count_reg  = COUNT_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic idx, logic [10:0] val);
      if (idx == CFG_ENABLE) begin
        enabled = val[0];
      end else begin
        count_reg = val;
      end
    endfunction

    function int unsigned active_clusters();
      return (32'(count_reg) > MAX_CLUSTERS) ? MAX_CLUSTERS : 32'(count_reg);
    endfunction

    function bit cluster_valid(logic [27:0] c);
      return enabled && 32'(c) >= 2 && 32'(c) < active_clusters() + 2;
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction

    // Predict the response for an accepted request and update the shadow table.
    function void note_request(req_t r);
      rsp_t        e;
      logic [27:0] c;
      logic [27:0] nxt;
      int unsigned n;
      int unsigned steps;
      e = '0;
      n = active_clusters();
      c = r.cluster;
      case (r.req_type)
        REQ_READ: begin
          if (cluster_valid(c)) begin
            e.entry_value = shadow_links[c[TW-1:0]];
          end else begin
            e.entry_value = ENTRY_BAD;
            e.status      = STATUS_INVALID;
          end
        end
        REQ_WRITE: begin
          if (cluster_valid(c)) begin
            shadow_links[c[TW-1:0]] = r.new_value;
          end else begin
            e.status = STATUS_INVALID;
          end
        end
        REQ_ALLOC: begin
          if (!enabled) begin
            e.status = STATUS_INVALID;
          end else begin
            e.status = STATUS_FULL;
            for (int unsigned k = 2; k < n + 2; k++) begin
              if (shadow_links[k[TW-1:0]] == ENTRY_FREE) begin
                shadow_links[k[TW-1:0]] = ENTRY_EOC;
                e.granted               = k[10:0];
                e.status                = STATUS_OK;
                break;
              end
            end
          end
        end
        REQ_FREE: begin
          if (!cluster_valid(c)) begin
            e.status = STATUS_INVALID;
          end else begin
            steps = 0;
            // Walk the chain, clearing as we go; stop on end-of-chain, a bad link or after n steps.
            while (cluster_valid(c) && steps < n) begin
              nxt                     = shadow_links[c[TW-1:0]];
              shadow_links[c[TW-1:0]] = ENTRY_FREE;
              steps++;
              if (nxt >= ENTRY_EOC_LO) break;
              c = nxt;
            end
          end
        end
        default: ;
      endcase
      expected_responses.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_responses.size() == 0) begin
        $error("response with nothing outstanding: entry_value %h granted %0d status %0d",
               got.entry_value, got.granted, got.status);
        mismatches++;
      end else begin
        want = expected_responses.pop_front();
        checked++;
        if (got.entry_value !== want.entry_value) begin
          $error("entry_value expected %h actual %h", want.entry_value, got.entry_value);
          mismatches++;
        end
        if (got.granted !== want.granted) begin
          $error("granted expected %0d actual %0d", want.granted, got.granted);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        result;
  logic        cfg_we;
  logic        cfg_index;
  logic [10:0] cfg_data;

  link_table_board sb;
  int unsigned     cycles;
  int              sent;
  int              settings;
  bit              gaps_on;

  cluster_chain_table #(.MAX_CLUSTERS(MAX_CLUSTERS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_response(result);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic req_t mk(logic [1:0] t, logic [27:0] c, logic [27:0] v);
    req_t r;
    r.req_type  = t;
    r.cluster   = c;
    r.new_value = v;
    return r;
  endfunction

  function automatic logic [27:0] pick_cluster(int unsigned n);
    logic [27:0] c;
    if (n > 0 && $urandom_range(99) < 80) begin
      c = 28'($urandom_range(2, n + 1));
    end else begin
      case ($urandom_range(3))
        0:       c = 28'd0;
        1:       c = 28'd1;
        2:       c = 28'(n + 2);
        default: c = 28'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic logic [27:0] pick_value(int unsigned n);
    int unsigned r;
    logic [27:0] v;
    r = $urandom_range(99);
    if (r < 40 && n > 0)  v = 28'($urandom_range(2, n + 1));
    else if (r < 55)      v = ENTRY_EOC_LO + 28'($urandom_range(7));
    else if (r < 63)      v = ENTRY_FREE;
    else if (r < 68)      v = ENTRY_BAD;
    else if (r < 73)      v = 28'($urandom_range(1));
    else                  v = 28'($urandom);
    return v;
  endfunction

  function automatic req_t random_request();
    int unsigned n;
    int unsigned r;
    logic [1:0]  t;
    n = sb.active_clusters();
    r = $urandom_range(99);
    if (r < 30)      t = REQ_READ;
    else if (r < 60) t = REQ_WRITE;
    else if (r < 80) t = REQ_ALLOC;
    else             t = REQ_FREE;
    return mk(t, pick_cluster(n), pick_value(n));
  endfunction

  // Present one request and hold it until the transfer; start stays high on return.
  task automatic issue(req_t r);
    gaps_on = !(sent >= 800 && sent < 1100);
    if (gaps_on && $urandom_range(99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic reconfigure(logic en, logic [10:0] cnt);
    logic [10:0] d;
    drain();
    d    = 11'($urandom);
    d[0] = en;
    write_reg(CFG_ENABLE, d);
    write_reg(CFG_COUNT, cnt);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Build a short chain by writes, then usually free it and read part of it back.
  task automatic chain_sequence();
    logic [27:0] links [0:5];
    int unsigned n;
    int          len;
    n   = sb.active_clusters();
    len = $urandom_range(2, 6);
    for (int i = 0; i < len; i++) links[i] = pick_cluster(n);
    for (int i = 0; i < len - 1; i++) issue(mk(REQ_WRITE, links[i], links[i + 1]));
    issue(mk(REQ_WRITE, links[len - 1],
             ($urandom_range(3) == 0) ? pick_value(n)
                                      : ENTRY_EOC_LO + 28'($urandom_range(7))));
    if ($urandom_range(9) < 7) issue(mk(REQ_FREE, links[0], 28'($urandom)));
    issue(mk(REQ_READ, links[$urandom_range(len - 1)], 28'($urandom)));
    if ($urandom_range(3) == 0) issue(mk(REQ_ALLOC, pick_cluster(n), 28'($urandom)));
  endtask

  initial begin
    int          phase;
    int          phase_end;
    int unsigned r;
    logic        en;
    logic [10:0] cnt;
    sb        = new();
    cycles    = 0;
    sent      = 0;
    settings  = 0;
    gaps_on   = 1'b1;
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Hold off until the post-reset clearing pass is over.
    while (busy !== 1'b0) @(posedge clk);

    // Table still unmounted: everything is rejected.
    issue(mk(REQ_READ,  28'd2, 28'd0));
    issue(mk(REQ_WRITE, 28'd2, 28'd5));
    issue(mk(REQ_ALLOC, 28'd0, 28'd0));
    issue(mk(REQ_FREE,  28'd2, 28'd0));

    reconfigure(1'b1, 11'd4);
    issue(mk(REQ_WRITE, 28'd0, 28'hFFFFFFF));
    issue(mk(REQ_WRITE, 28'd6, 28'd3));
    issue(mk(REQ_READ,  28'hFFFFFFF, 28'd0));
    issue(mk(REQ_ALLOC, 28'd0, 28'd0));
    issue(mk(REQ_ALLOC, 28'd0, 28'd0));
    issue(mk(REQ_WRITE, 28'd4, 28'hFFFFFFF));
    issue(mk(REQ_WRITE, 28'd5, ENTRY_BAD));
    issue(mk(REQ_ALLOC, 28'd0, 28'd0));
    issue(mk(REQ_READ,  28'd5, 28'd0));
    issue(mk(REQ_WRITE, 28'd2, 28'd3));
    issue(mk(REQ_WRITE, 28'd3, 28'd4));
    issue(mk(REQ_WRITE, 28'd4, ENTRY_EOC_LO));
    issue(mk(REQ_FREE,  28'd2, 28'd0));
    issue(mk(REQ_READ,  28'd3, 28'd0));
    issue(mk(REQ_FREE,  28'd5, 28'd0));
    issue(mk(REQ_FREE,  28'd1, 28'd0));
    issue(mk(REQ_READ,  28'd1, 28'd0));

    reconfigure(1'b1, 11'd0);
    issue(mk(REQ_ALLOC, 28'd0, 28'd0));
    issue(mk(REQ_READ,  28'd2, 28'd0));

    // Count above the table size saturates.
    reconfigure(1'b1, 11'h7FF);
    issue(mk(REQ_WRITE, 28'd1025, 28'hFFFFFFF));
    issue(mk(REQ_READ,  28'd1025, 28'd0));
    issue(mk(REQ_READ,  28'd1026, 28'd0));
    issue(mk(REQ_ALLOC, 28'd0, 28'd0));

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      r  = $urandom_range(99);
      en = ($urandom_range(99) < 90);
      if (phase == 0)  cnt = COUNT_RESET;
      else if (r < 6)  cnt = 11'd0;
      else if (r < 14) cnt = 11'd1;
      else if (r < 22) cnt = 11'd2;
      else if (r < 68) cnt = 11'($urandom_range(3, 32));
      else if (r < 84) cnt = 11'($urandom_range(33, 200));
      else if (r < 93) cnt = COUNT_RESET;
      else             cnt = 11'($urandom_range(1025, 2047));
      if (phase == 0) en = 1'b1;
      reconfigure(en, cnt);
      phase_end = sent + ((cnt > 11'd200) ? 30 : 110);
      while (sent < phase_end) begin
        if ($urandom_range(99) < 60) chain_sequence();
        else                         issue(random_request());
      end
      phase++;
    end

    drain();
    repeat (30) @(posedge clk);
    $display("Ran directed cases and %0d random requests over %0d table settings;", sent, settings);
    $display("%0d responses compared, %0d field mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
